// ----- hdl/assert_macros.svh -----
// Assertion macros for the grid walker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("walker assertion failed");

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("walker forbidden condition seen");

`endif

// ----- hdl/rogdw_pkg.sv -----
`default_nettype none

package rogdw_pkg;

  localparam int unsigned GRID_WIDTH_DEF  = 32;
  localparam int unsigned GRID_HEIGHT_DEF = 32;

  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COORD_W   = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned ORDER_W   = 2;
  localparam int unsigned TRIED_W   = 3;
  localparam int unsigned EPOCH_W   = 6;

  localparam logic [TRIED_W-1:0] NEIGHBOURS = 3'd4;
  localparam logic [EPOCH_W-1:0] EPOCH_MAX  = '1;

  localparam logic [CFG_W-1:0] START_COL_RST = 5'd0;
  localparam logic [CFG_W-1:0] START_ROW_RST = 5'd0;
  localparam logic [CFG_W-1:0] GOAL_COL_RST  = 5'd29;
  localparam logic [CFG_W-1:0] GOAL_ROW_RST  = 5'd29;

  localparam logic CMD_BEGIN = 1'b0;

  localparam logic [STATUS_W-1:0] STATUS_NEW  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_GOAL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_COL = 2'd0,
    CFG_START_ROW = 2'd1,
    CFG_GOAL_COL  = 2'd2,
    CFG_GOAL_ROW  = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIR_E = 2'd0,
    DIR_W = 2'd1,
    DIR_S = 2'd2,
    DIR_N = 2'd3
  } dir_e;

  typedef struct packed {
    logic               command;
    logic [ORDER_W-1:0] order_choice;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0]  cell_col;
    logic [COORD_W-1:0]  cell_row;
    logic [STATUS_W-1:0] walk_status;
  } out_item_t;

  typedef enum logic [3:0] {
    U_IDLE     = 4'd0,
    U_DISPATCH = 4'd1,
    U_ACTIVE   = 4'd2,
    U_FRAME    = 4'd3,
    U_PROBE    = 4'd4,
    U_CHECK    = 4'd5,
    U_ENTER    = 4'd6,
    U_POP      = 4'd7,
    U_LOAD     = 4'd8,
    U_OVER     = 4'd9,
    U_BEGIN    = 4'd10,
    U_CLEAR    = 4'd11,
    U_START    = 4'd12
  } upc_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_SET_ORDER,
    OP_PROBE,
    OP_ENTER,
    OP_POP,
    OP_LOAD,
    OP_OVER,
    OP_BEGIN,
    OP_CLEAR,
    OP_START
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_XFER,
    C_BEGIN,
    C_INACTIVE,
    C_TRIED_FULL,
    C_CAND_BAD,
    C_LAST_FRAME,
    C_EPOCH_OK,
    C_SWEEP_MORE
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_e  target;
    logic  emit;
  } ctl_t;

  function automatic ctl_t ucode(upc_e pc);
    ctl_t w;
    unique case (pc)
      U_IDLE:     w = '{op: OP_ACCEPT,    cond: C_NO_XFER,    target: U_IDLE,  emit: 1'b0};
      U_DISPATCH: w = '{op: OP_NONE,      cond: C_BEGIN,      target: U_BEGIN, emit: 1'b0};
      U_ACTIVE:   w = '{op: OP_NONE,      cond: C_INACTIVE,   target: U_OVER,  emit: 1'b0};
      U_FRAME:    w = '{op: OP_SET_ORDER, cond: C_TRIED_FULL, target: U_POP,   emit: 1'b0};
      U_PROBE:    w = '{op: OP_PROBE,     cond: C_NEVER,      target: U_IDLE,  emit: 1'b0};
      U_CHECK:    w = '{op: OP_NONE,      cond: C_CAND_BAD,   target: U_FRAME, emit: 1'b0};
      U_ENTER:    w = '{op: OP_ENTER,     cond: C_ALWAYS,     target: U_IDLE,  emit: 1'b1};
      U_POP:      w = '{op: OP_POP,       cond: C_LAST_FRAME, target: U_OVER,  emit: 1'b0};
      U_LOAD:     w = '{op: OP_LOAD,      cond: C_ALWAYS,     target: U_FRAME, emit: 1'b0};
      U_OVER:     w = '{op: OP_OVER,      cond: C_ALWAYS,     target: U_IDLE,  emit: 1'b1};
      U_BEGIN:    w = '{op: OP_BEGIN,     cond: C_EPOCH_OK,   target: U_START, emit: 1'b0};
      U_CLEAR:    w = '{op: OP_CLEAR,     cond: C_SWEEP_MORE, target: U_CLEAR, emit: 1'b0};
      U_START:    w = '{op: OP_START,     cond: C_ALWAYS,     target: U_IDLE,  emit: 1'b1};
      default:    w = '{op: OP_NONE,      cond: C_ALWAYS,     target: U_IDLE,  emit: 1'b0};
    endcase
    return w;
  endfunction

  function automatic dir_e order_dir(logic [ORDER_W-1:0] ord, logic [1:0] idx);
    dir_e d;
    unique case (ord)
      2'd0: begin
        unique case (idx)
          2'd0: d = DIR_E;
          2'd1: d = DIR_W;
          2'd2: d = DIR_S;
          default: d = DIR_N;
        endcase
      end
      2'd1: begin
        unique case (idx)
          2'd0: d = DIR_E;
          2'd1: d = DIR_S;
          2'd2: d = DIR_W;
          default: d = DIR_N;
        endcase
      end
      2'd2: begin
        unique case (idx)
          2'd0: d = DIR_S;
          2'd1: d = DIR_W;
          2'd2: d = DIR_E;
          default: d = DIR_N;
        endcase
      end
      default: begin
        unique case (idx)
          2'd0: d = DIR_S;
          2'd1: d = DIR_N;
          2'd2: d = DIR_E;
          default: d = DIR_W;
        endcase
      end
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/random_order_grid_dfs_walker_top.sv -----
// Channel | Dir | Transfer when                | Payload
// in      | in  | in_valid_i & in_ready_o      | in_data_i  (command, order_choice)
// out     | out | out_valid_o & out_ready_i    | out_data_o (cell_col, cell_row, walk_status)
// cfg     | in  | cfg_we_i                     | cfg_idx_i, cfg_data_i
//
// One sequencer step per cycle while no emitting step stalls; the visited
// map has one read port, so each neighbour probe takes the steps order, probe
// and check, and each pop the steps pop and load. An advance runs idle,
// dispatch and active, then those steps, and ends in enter or over. A begin
// runs idle, dispatch, begin and start. After reset, and on every 63rd begin
// after that, begin first clears each entry of the visited map, taking no input.
// A result held by out_ready_i low stalls the step that emits the next one.
`default_nettype none

`include "assert_macros.svh"

module random_order_grid_dfs_walker_top #(
  parameter int unsigned GRID_WIDTH  = rogdw_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT = rogdw_pkg::GRID_HEIGHT_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire rogdw_pkg::in_item_t                in_data_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output rogdw_pkg::out_item_t                    out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [rogdw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [rogdw_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned CW         = $clog2(GRID_WIDTH);
  localparam int unsigned RW         = $clog2(GRID_HEIGHT);
  localparam int unsigned CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW         = $clog2(CELL_COUNT);
  localparam int unsigned LW         = $clog2(CELL_COUNT + 1);
  localparam int unsigned OW         = rogdw_pkg::ORDER_W;
  localparam int unsigned TW         = rogdw_pkg::TRIED_W;
  localparam int unsigned EW         = rogdw_pkg::EPOCH_W;
  localparam int unsigned FW         = CW + RW + OW + TW;

  rogdw_pkg::upc_e upc_q, upc_d;
  rogdw_pkg::ctl_t ctl;
  logic            cond_true;
  logic            stall;
  logic            in_xfer;
  logic            act;

  logic [rogdw_pkg::CFG_W-1:0] cfg_start_col_q, cfg_start_row_q;
  logic [rogdw_pkg::CFG_W-1:0] cfg_goal_col_q, cfg_goal_row_q;

  logic          walk_active_q, walk_active_d;
  logic [LW-1:0] level_q, level_d;
  logic [EW-1:0] epoch_q, epoch_d;
  logic [AW-1:0] sweep_q, sweep_d;
  logic          out_valid_q, out_valid_d;

  logic                 cmd_q, cmd_d;
  logic [OW-1:0]        choice_q, choice_d;
  logic [CW-1:0]        top_col_q, top_col_d;
  logic [RW-1:0]        top_row_q, top_row_d;
  logic [OW-1:0]        top_ord_q, top_ord_d;
  logic [TW-1:0]        top_tried_q, top_tried_d;
  logic                 top_pend_q, top_pend_d;
  logic [CW-1:0]        cand_col_q, cand_col_d;
  logic [RW-1:0]        cand_row_q, cand_row_d;
  logic                 cand_ok_q, cand_ok_d;
  rogdw_pkg::out_item_t out_data_q, out_data_d;

  rogdw_pkg::dir_e nb_dir;
  logic [CW-1:0]   nb_col;
  logic [RW-1:0]   nb_row;
  logic            nb_ok;
  logic [AW-1:0]   nb_idx, cand_idx, start_idx;
  logic            start_ok, start_goal, cand_goal;
  logic [CW-1:0]   start_col;
  logic [RW-1:0]   start_row;

  logic          vis_we, vis_re;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic [EW-1:0] vis_wdata, vis_rdata;
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  logic [FW-1:0] stk_wdata, stk_rdata;

  rogdw_ram #(.WIDTH(EW), .DEPTH(CELL_COUNT)) u_visited (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (vis_re),
    .raddr_i (vis_raddr),
    .rdata_o (vis_rdata)
  );

  rogdw_ram #(.WIDTH(FW), .DEPTH(CELL_COUNT)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // neighbour of the top frame in its current try slot
  always_comb begin
    nb_dir = rogdw_pkg::order_dir(top_ord_q, top_tried_q[1:0]);
    nb_col = top_col_q;
    nb_row = top_row_q;
    nb_ok  = 1'b0;
    unique case (nb_dir)
      rogdw_pkg::DIR_E: begin
        nb_ok = (top_col_q != CW'(GRID_WIDTH - 1));
        if (nb_ok) nb_col = top_col_q + CW'(1);
      end
      rogdw_pkg::DIR_W: begin
        nb_ok = (top_col_q != '0);
        if (nb_ok) nb_col = top_col_q - CW'(1);
      end
      rogdw_pkg::DIR_S: begin
        nb_ok = (top_row_q != RW'(GRID_HEIGHT - 1));
        if (nb_ok) nb_row = top_row_q + RW'(1);
      end
      default: begin
        nb_ok = (top_row_q != '0);
        if (nb_ok) nb_row = top_row_q - RW'(1);
      end
    endcase
  end

  assign start_ok   = (32'(cfg_start_col_q) < GRID_WIDTH) && (32'(cfg_start_row_q) < GRID_HEIGHT);
  assign start_col  = CW'(cfg_start_col_q);
  assign start_row  = RW'(cfg_start_row_q);
  assign start_goal = (cfg_start_col_q == cfg_goal_col_q) && (cfg_start_row_q == cfg_goal_row_q);
  assign cand_goal  = (32'(cand_col_q) == 32'(cfg_goal_col_q)) &&
                      (32'(cand_row_q) == 32'(cfg_goal_row_q));

  assign nb_idx    = AW'(32'(nb_row) * GRID_WIDTH + 32'(nb_col));
  assign cand_idx  = AW'(32'(cand_row_q) * GRID_WIDTH + 32'(cand_col_q));
  assign start_idx = AW'(32'(start_row) * GRID_WIDTH + 32'(start_col));

  // sequencer
  always_comb begin
    ctl = rogdw_pkg::ucode(upc_q);
    in_ready_o = (ctl.op == rogdw_pkg::OP_ACCEPT);
    in_xfer    = in_valid_i && in_ready_o;
    stall      = ctl.emit && out_valid_q && !out_ready_i;
    act        = !stall;
    unique case (ctl.cond)
      rogdw_pkg::C_NEVER:      cond_true = 1'b0;
      rogdw_pkg::C_ALWAYS:     cond_true = 1'b1;
      rogdw_pkg::C_NO_XFER:    cond_true = !in_xfer;
      rogdw_pkg::C_BEGIN:      cond_true = (cmd_q == rogdw_pkg::CMD_BEGIN);
      rogdw_pkg::C_INACTIVE:   cond_true = !walk_active_q;
      rogdw_pkg::C_TRIED_FULL: cond_true = (top_tried_q == rogdw_pkg::NEIGHBOURS);
      rogdw_pkg::C_CAND_BAD:   cond_true = !cand_ok_q || (vis_rdata == epoch_q);
      rogdw_pkg::C_LAST_FRAME: cond_true = (level_q == LW'(1));
      rogdw_pkg::C_EPOCH_OK:   cond_true = (epoch_q != rogdw_pkg::EPOCH_MAX);
      rogdw_pkg::C_SWEEP_MORE: cond_true = (sweep_q != AW'(CELL_COUNT - 1));
      default:                 cond_true = 1'b0;
    endcase
    if (stall) begin
      upc_d = upc_q;
    end else if (cond_true) begin
      upc_d = ctl.target;
    end else begin
      upc_d = rogdw_pkg::upc_e'(upc_q + 4'd1);
    end
  end

  // datapath
  always_comb begin
    walk_active_d = walk_active_q;
    level_d       = level_q;
    epoch_d       = epoch_q;
    sweep_d       = sweep_q;
    cmd_d         = cmd_q;
    choice_d      = choice_q;
    top_col_d     = top_col_q;
    top_row_d     = top_row_q;
    top_ord_d     = top_ord_q;
    top_tried_d   = top_tried_q;
    top_pend_d    = top_pend_q;
    cand_col_d    = cand_col_q;
    cand_row_d    = cand_row_q;
    cand_ok_d     = cand_ok_q;
    out_data_d    = out_data_q;
    out_valid_d   = out_valid_q && !out_ready_i;

    vis_we    = 1'b0;
    vis_waddr = cand_idx;
    vis_wdata = epoch_q;
    vis_re    = 1'b0;
    vis_raddr = nb_idx;
    stk_we    = 1'b0;
    stk_waddr = AW'(level_q - LW'(1));
    stk_wdata = {top_col_q, top_row_q, top_ord_q, top_tried_q};
    stk_re    = 1'b0;
    stk_raddr = AW'(level_q - LW'(2));

    unique case (ctl.op)
      rogdw_pkg::OP_ACCEPT: begin
        if (in_xfer) begin
          cmd_d    = in_data_i.command;
          choice_d = in_data_i.order_choice;
        end
      end
      rogdw_pkg::OP_SET_ORDER: begin
        if (top_pend_q) begin
          top_ord_d  = choice_q;
          top_pend_d = 1'b0;
        end
      end
      rogdw_pkg::OP_PROBE: begin
        vis_re      = 1'b1;
        cand_col_d  = nb_col;
        cand_row_d  = nb_row;
        cand_ok_d   = nb_ok;
        top_tried_d = top_tried_q + TW'(1);
      end
      rogdw_pkg::OP_ENTER: begin
        if (act) begin
          vis_we      = 1'b1;
          out_valid_d = 1'b1;
          out_data_d  = '{cell_col: rogdw_pkg::COORD_W'(cand_col_q),
                          cell_row: rogdw_pkg::COORD_W'(cand_row_q),
                          walk_status: rogdw_pkg::STATUS_NEW};
          if (cand_goal) begin
            walk_active_d          = 1'b0;
            out_data_d.walk_status = rogdw_pkg::STATUS_GOAL;
          end else if (level_q < LW'(CELL_COUNT)) begin
            stk_we      = (level_q != '0);
            top_col_d   = cand_col_q;
            top_row_d   = cand_row_q;
            top_ord_d   = '0;
            top_tried_d = '0;
            top_pend_d  = 1'b1;
            level_d     = level_q + LW'(1);
          end
        end
      end
      rogdw_pkg::OP_POP: begin
        stk_re  = 1'b1;
        level_d = level_q - LW'(1);
        if (level_q == LW'(1)) walk_active_d = 1'b0;
      end
      rogdw_pkg::OP_LOAD: begin
        top_col_d   = stk_rdata[FW-1 -: CW];
        top_row_d   = stk_rdata[RW+OW+TW-1 -: RW];
        top_ord_d   = stk_rdata[OW+TW-1 -: OW];
        top_tried_d = stk_rdata[TW-1:0];
        top_pend_d  = 1'b0;
      end
      rogdw_pkg::OP_OVER: begin
        if (act) begin
          walk_active_d = 1'b0;
          level_d       = '0;
          out_valid_d   = 1'b1;
          out_data_d    = '{cell_col: '0, cell_row: '0,
                            walk_status: rogdw_pkg::STATUS_OVER};
        end
      end
      rogdw_pkg::OP_BEGIN: begin
        walk_active_d = 1'b0;
        level_d       = '0;
        if (epoch_q == rogdw_pkg::EPOCH_MAX) begin
          epoch_d = EW'(1);
          sweep_d = '0;
        end else begin
          epoch_d = epoch_q + EW'(1);
        end
      end
      rogdw_pkg::OP_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = sweep_q;
        vis_wdata = '0;
        sweep_d   = sweep_q + AW'(1);
      end
      rogdw_pkg::OP_START: begin
        vis_waddr = start_idx;
        if (act) begin
          out_valid_d = 1'b1;
          if (!start_ok) begin
            out_data_d = '{cell_col: '0, cell_row: '0,
                           walk_status: rogdw_pkg::STATUS_OVER};
          end else begin
            vis_we     = 1'b1;
            out_data_d = '{cell_col: cfg_start_col_q, cell_row: cfg_start_row_q,
                           walk_status: rogdw_pkg::STATUS_NEW};
            if (start_goal) begin
              out_data_d.walk_status = rogdw_pkg::STATUS_GOAL;
            end else begin
              walk_active_d = 1'b1;
              level_d       = LW'(1);
              top_col_d     = start_col;
              top_row_d     = start_row;
              top_ord_d     = '0;
              top_tried_d   = '0;
              top_pend_d    = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q           <= rogdw_pkg::U_IDLE;
      walk_active_q   <= 1'b0;
      level_q         <= '0;
      epoch_q         <= rogdw_pkg::EPOCH_MAX;
      sweep_q         <= '0;
      out_valid_q     <= 1'b0;
      cfg_start_col_q <= rogdw_pkg::START_COL_RST;
      cfg_start_row_q <= rogdw_pkg::START_ROW_RST;
      cfg_goal_col_q  <= rogdw_pkg::GOAL_COL_RST;
      cfg_goal_row_q  <= rogdw_pkg::GOAL_ROW_RST;
    end else begin
      upc_q         <= upc_d;
      walk_active_q <= walk_active_d;
      level_q       <= level_d;
      epoch_q       <= epoch_d;
      sweep_q       <= sweep_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rogdw_pkg::CFG_START_COL: cfg_start_col_q <= cfg_data_i;
          rogdw_pkg::CFG_START_ROW: cfg_start_row_q <= cfg_data_i;
          rogdw_pkg::CFG_GOAL_COL:  cfg_goal_col_q  <= cfg_data_i;
          rogdw_pkg::CFG_GOAL_ROW:  cfg_goal_row_q  <= cfg_data_i;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    choice_q    <= choice_d;
    top_col_q   <= top_col_d;
    top_row_q   <= top_row_d;
    top_ord_q   <= top_ord_d;
    top_tried_q <= top_tried_d;
    top_pend_q  <= top_pend_d;
    cand_col_q  <= cand_col_d;
    cand_row_q  <= cand_row_d;
    cand_ok_q   <= cand_ok_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_NEVER(a_active_has_frame, clk_i, rst_ni, walk_active_q && (level_q == '0))
  `ASSERT_NEVER(a_level_bound, clk_i, rst_ni, level_q > LW'(CELL_COUNT))
  `ASSERT_AT(a_cand_in_grid, clk_i, rst_ni, (upc_q == rogdw_pkg::U_CHECK) && cand_ok_q |-> (32'(cand_col_q) < GRID_WIDTH) && (32'(cand_row_q) < GRID_HEIGHT))

endmodule

`default_nettype wire

// ----- hdl/rogdw_ram.sv -----
`default_nettype none

module rogdw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sim/random_order_grid_dfs_walker_top_tb.sv -----
module random_order_grid_dfs_walker_top_tb;
  import rogdw_pkg::*;

  localparam int GRID_W = GRID_WIDTH_DEF;
  localparam int GRID_H = GRID_HEIGHT_DEF;
  localparam int CELLS = GRID_W * GRID_H;
  localparam int COMMAND_TARGET = 1150;
  localparam int WATCHDOG_LIMIT = 100000;
  localparam int IDLE_PCT = 13;
  localparam logic CMD_ADVANCE = ~CMD_BEGIN;

  // neighbour orders, slot 0 first
  localparam logic [0:3][0:3][1:0] ORDER_DIRS = {
    DIR_E, DIR_W, DIR_S, DIR_N,
    DIR_E, DIR_S, DIR_W, DIR_N,
    DIR_S, DIR_W, DIR_E, DIR_N,
    DIR_S, DIR_N, DIR_E, DIR_W
  };

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [ORDER_W-1:0] order;
    logic [TRIED_W-1:0] tried;
    logic               pending;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  cfg_idx_e cfg_idx = CFG_START_COL;
  logic [CFG_W-1:0] cfg_data = '0;

  logic [CFG_W-1:0] start_col = START_COL_RST;
  logic [CFG_W-1:0] start_row = START_ROW_RST;
  logic [CFG_W-1:0] goal_col = GOAL_COL_RST;
  logic [CFG_W-1:0] goal_row = GOAL_ROW_RST;

  bit visited [CELLS];
  frame_t frames [CELLS];
  int depth = 0;
  bit walking = 1'b0;

  out_item_t cells_due [$];
  int commands_sent = 0;
  int mismatches = 0;
  bit steady = 1'b0;

  random_order_grid_dfs_walker_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [STATUS_W-1:0] enter_cell(input logic [COORD_W-1:0] c,
                                                     input logic [COORD_W-1:0] r);
    visited[int'(r) * GRID_W + int'(c)] = 1'b1;
    if (c == goal_col && r == goal_row) begin
      walking = 1'b0;
      return STATUS_GOAL;
    end
    if (depth < CELLS) begin
      frames[depth] = '{col: c, row: r, order: '0, tried: '0, pending: 1'b1};
      depth++;
    end
    return STATUS_NEW;
  endfunction

  function automatic out_item_t next_cell(input in_item_t item);
    out_item_t res;
    int top;
    int nc;
    int nr;
    dir_e dir;
    res = '{cell_col: '0, cell_row: '0, walk_status: STATUS_OVER};
    if (item.command == CMD_BEGIN) begin
      foreach (visited[i]) visited[i] = 1'b0;
      depth = 0;
      walking = 1'b0;
      if (start_col >= GRID_W || start_row >= GRID_H) return res;
      walking = 1'b1;
      res.cell_col = start_col;
      res.cell_row = start_row;
      res.walk_status = enter_cell(start_col, start_row);
      return res;
    end
    if (!walking) return res;
    while (depth > 0) begin
      top = depth - 1;
      if (frames[top].pending) begin
        frames[top].order = item.order_choice;
        frames[top].pending = 1'b0;
      end
      while (frames[top].tried < NEIGHBOURS) begin
        dir = dir_e'(ORDER_DIRS[frames[top].order][frames[top].tried[1:0]]);
        nc = frames[top].col;
        nr = frames[top].row;
        frames[top].tried = frames[top].tried + 1'b1;
        case (dir)
          DIR_E: nc = nc + 1;
          DIR_W: nc = nc - 1;
          DIR_S: nr = nr + 1;
          default: nr = nr - 1;
        endcase
        if (nc >= 0 && nc < GRID_W && nr >= 0 && nr < GRID_H &&
            !visited[nr * GRID_W + nc]) begin
          res.cell_col = COORD_W'(nc);
          res.cell_row = COORD_W'(nr);
          res.walk_status = enter_cell(COORD_W'(nc), COORD_W'(nr));
          return res;
        end
      end
      depth--;
    end
    walking = 1'b0;
    return res;
  endfunction

  function automatic logic [CFG_W-1:0] near_coord(input logic [CFG_W-1:0] c);
    int t;
    t = int'(c) + int'($urandom_range(8)) - 4;
    if (t < 0) t = 0;
    if (t > GRID_W - 1) t = GRID_W - 1;
    return CFG_W'(t);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic send_item(input logic cmd, input logic [ORDER_W-1:0] choice);
    in_item_t item;
    item.command = cmd;
    item.order_choice = choice;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    cells_due.push_back(next_cell(item));
    commands_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (cells_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic place_walk(input logic [CFG_W-1:0] sc, input logic [CFG_W-1:0] sr,
                            input logic [CFG_W-1:0] gc, input logic [CFG_W-1:0] gr);
    settle();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_START_COL;
    cfg_data <= sc;
    @(posedge clk);
    cfg_idx <= CFG_START_ROW;
    cfg_data <= sr;
    @(posedge clk);
    cfg_idx <= CFG_GOAL_COL;
    cfg_data <= gc;
    @(posedge clk);
    cfg_idx <= CFG_GOAL_ROW;
    cfg_data <= gr;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_col = sc;
    start_row = sr;
    goal_col = gc;
    goal_row = gr;
  endtask

  task automatic test_inactive_advance();
    for (int ch = 0; ch < 4; ch++) send_item(CMD_ADVANCE, ORDER_W'(ch));
  endtask

  task automatic test_reset_walk();
    send_item(CMD_BEGIN, 2'd0);
    for (int ch = 3; ch >= 0; ch--) send_item(CMD_ADVANCE, ORDER_W'(ch));
  endtask

  task automatic test_start_on_goal();
    place_walk('1, '1, '1, '1);
    send_item(CMD_BEGIN, 2'd3);
    send_item(CMD_ADVANCE, 2'd1);
    place_walk('0, '0, '0, '0);
    send_item(CMD_BEGIN, 2'd2);
    send_item(CMD_ADVANCE, 2'd0);
  endtask

  task automatic test_corner_starts();
    place_walk('1, '0, '1, 5'd1);
    send_item(CMD_BEGIN, 2'd1);
    for (int ch = 0; ch < 3; ch++) send_item(CMD_ADVANCE, ORDER_W'(ch));
    place_walk('0, '1, 5'd1, '1);
    send_item(CMD_BEGIN, 2'd0);
    for (int ch = 1; ch < 4; ch++) send_item(CMD_ADVANCE, ORDER_W'(ch));
    place_walk('1, '1, '0, '0);
    send_item(CMD_BEGIN, 2'd3);
    for (int ch = 3; ch > 0; ch--) send_item(CMD_ADVANCE, ORDER_W'(ch));
  endtask

  task automatic test_steady_stream();
    place_walk('0, '0, '1, '1);
    steady = 1'b1;
    send_item(CMD_BEGIN, ORDER_W'($urandom_range(3)));
    for (int n = 0; n < 150 && walking; n++)
      send_item(CMD_ADVANCE, ORDER_W'($urandom_range(3)));
    steady = 1'b0;
  endtask

  task automatic test_random_walks();
    logic [CFG_W-1:0] sc;
    logic [CFG_W-1:0] sr;
    logic [CFG_W-1:0] gc;
    logic [CFG_W-1:0] gr;
    int cap;
    int steps;
    while (commands_sent < COMMAND_TARGET) begin
      if ($urandom_range(99) < 60) begin
        sc = CFG_W'($urandom_range(GRID_W - 1));
        sr = CFG_W'($urandom_range(GRID_H - 1));
        case ($urandom_range(3))
          0: begin
            gc = CFG_W'($urandom_range(GRID_W - 1));
            gr = CFG_W'($urandom_range(GRID_H - 1));
          end
          1: begin
            gc = $urandom_range(1) ? '1 : '0;
            gr = $urandom_range(1) ? '1 : '0;
          end
          default: begin
            gc = near_coord(sc);
            gr = near_coord(sr);
          end
        endcase
        place_walk(sc, sr, gc, gr);
      end
      send_item(CMD_BEGIN, ORDER_W'($urandom_range(3)));
      cap = ($urandom_range(99) < 25) ? $urandom_range(400, 100) : $urandom_range(60, 3);
      steps = 0;
      while (walking && steps < cap && commands_sent < COMMAND_TARGET) begin
        if ($urandom_range(99) < 2) settle();
        send_item(CMD_ADVANCE, ORDER_W'($urandom_range(3)));
        steps++;
      end
      repeat ($urandom_range(2)) send_item(CMD_ADVANCE, ORDER_W'($urandom_range(3)));
    end
  endtask

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (cells_due.size() == 0) begin
        report_mismatch("unexpected transfer, status", out_data.walk_status, -1);
      end else begin
        want = cells_due.pop_front();
        if (out_data.cell_col !== want.cell_col)
          report_mismatch("cell_col", out_data.cell_col, want.cell_col);
        if (out_data.cell_row !== want.cell_row)
          report_mismatch("cell_row", out_data.cell_row, want.cell_row);
        if (out_data.walk_status !== want.walk_status)
          report_mismatch("walk_status", out_data.walk_status, want.walk_status);
      end
    end
  end

  initial begin
    int quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("random_order_grid_dfs_walker_top test failed");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_inactive_advance();
    test_reset_walk();
    test_start_on_goal();
    test_corner_starts();
    test_steady_stream();
    test_random_walks();
    settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && cells_due.size() == 0) begin
      $display("random_order_grid_dfs_walker_top test passed");
    end else begin
      $display("random_order_grid_dfs_walker_top test failed");
    end
    $finish;
  end

endmodule
